/* sv/tbs_pkg.sv */
// Package for the wrapped bilinear texture sampler.
// Holds shared widths, command and register codes, and the read tag type.
// No dependencies.
package tbs_pkg;

    localparam int TexelCount = 65536;
    localparam int AddrW      = $clog2(TexelCount);
    localparam int FracBits   = 8;
    localparam int SizeW      = 9;
    localparam int CoordW     = 24;
    localparam int CoordFracW = 16;
    localparam int ProdW      = CoordFracW + SizeW;
    localparam int WeightW    = 2 * FracBits + 1;
    localparam int ChanW      = 8;
    localparam int RgbW       = 3 * ChanW;
    localparam int AccW       = ChanW + WeightW;
    localparam int OutW       = 16;
    localparam int OutShift   = 2 * FracBits - 8;
    localparam int CfgIdxW    = 2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic MODE_POINT    = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam logic [CfgIdxW-1:0] REG_TEX_WIDTH   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_TEX_HEIGHT  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_FILTER_MODE = 2'd2;

    // Travels alongside each texel read so the blend stage can weight it.
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic [WeightW-1:0] weight;
    } rd_tag_t;

endpackage

/* sv/tbs_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module tbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/tbs_issue.sv */
// Item register and read sequencer: scales coordinates, wraps them,
// generates texel addresses and weights, and drives the texel RAM port.
// Depends on tbs_pkg.
module tbs_issue
    import tbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  command,
    input  logic [15:0]           texel_index,
    input  logic [RgbW-1:0]       texel_rgb,
    input  logic signed [CoordW-1:0] u_coord,
    input  logic signed [CoordW-1:0] v_coord,
    input  logic [SizeW-1:0]      width_eff,
    input  logic [SizeW-1:0]      height_eff,
    input  logic                  mode,
    output logic                  busy,
    output logic                  ram_we,
    output logic [AddrW-1:0]      ram_addr,
    output logic [RgbW-1:0]       ram_wdata,
    output rd_tag_t               tag_reg
);

    localparam logic [FracBits:0] One = (FracBits + 1)'(1 << FracBits);

    logic              valid_reg, valid_next;
    logic              cmd_reg;
    logic [15:0]       idx_reg;
    logic [RgbW-1:0]   rgb_reg;
    logic [ProdW-1:0]  pu_reg, pv_reg;
    logic [1:0]        k_reg, k_next;
    rd_tag_t           tag_next;
    logic              accept, last_issue, bilin;
    logic [SizeW-1:0]  x, y, x1, y1, col, row;
    logic [SizeW:0]    xp, yp;
    logic [FracBits-1:0] fx, fy;
    logic [FracBits:0] fa, fb;
    logic [2*FracBits+1:0] wprod;
    logic [2*SizeW-1:0] lin;

    assign bilin      = (mode == MODE_BILINEAR);
    assign last_issue = (cmd_reg == CMD_WRITE) || !bilin || (k_reg == 2'd3);
    assign busy       = valid_reg && !last_issue;
    assign accept     = start && !busy;

    // Only the fractional part of a coordinate decides the wrapped texel.
    assign x  = pu_reg[ProdW-1:CoordFracW];
    assign y  = pv_reg[ProdW-1:CoordFracW];
    assign fx = pu_reg[CoordFracW-1 -: FracBits];
    assign fy = pv_reg[CoordFracW-1 -: FracBits];
    assign xp = {1'b0, x} + 1'b1;
    assign yp = {1'b0, y} + 1'b1;
    assign x1 = (xp >= {1'b0, width_eff})  ? '0 : xp[SizeW-1:0];
    assign y1 = (yp >= {1'b0, height_eff}) ? '0 : yp[SizeW-1:0];

    always_comb
    begin
        col = (k_reg == 2'd0 || k_reg == 2'd3) ? x : x1;
        row = (k_reg == 2'd0 || k_reg == 2'd1) ? y : y1;
        if (bilin)
        begin
            fa = (k_reg == 2'd0 || k_reg == 2'd3) ? One - {1'b0, fx} : {1'b0, fx};
            fb = (k_reg == 2'd0 || k_reg == 2'd1) ? One - {1'b0, fy} : {1'b0, fy};
        end
        else
        begin
            fa = One;
            fb = One;
        end
        wprod = fa * fb;
        lin   = (2*SizeW)'(row) * (2*SizeW)'(width_eff) + (2*SizeW)'(col);

        ram_we    = valid_reg && (cmd_reg == CMD_WRITE);
        ram_wdata = rgb_reg;
        ram_addr  = (cmd_reg == CMD_WRITE) ? AddrW'(idx_reg) : lin[AddrW-1:0];

        tag_next.valid  = valid_reg && (cmd_reg == CMD_SAMPLE);
        tag_next.first  = (k_reg == 2'd0);
        tag_next.last   = last_issue;
        tag_next.weight = wprod[WeightW-1:0];

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (last_issue)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end

        if (!valid_reg || last_issue)
        begin
            k_next = 2'd0;
        end
        else
        begin
            k_next = k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            k_reg     <= 2'd0;
            tag_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            k_reg     <= k_next;
            tag_reg   <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            idx_reg <= texel_index;
            rgb_reg <= texel_rgb;
            pu_reg  <= ProdW'(u_coord[CoordFracW-1:0]) * ProdW'(width_eff);
            pv_reg  <= ProdW'(v_coord[CoordFracW-1:0]) * ProdW'(height_eff);
        end
    end

`ifndef SYNTHESIS
    a_busy_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (valid_reg && cmd_reg == CMD_SAMPLE))
        else $error("busy without a sample in progress");
    a_k_only_bilinear: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != 2'd0) |-> (valid_reg && cmd_reg == CMD_SAMPLE && bilin))
        else $error("read counter running outside a bilinear sample");
    a_tag_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg.valid |-> $past(valid_reg && !ram_we))
        else $error("read tag without a texel read");
`endif

endmodule

/* sv/tbs_blend.sv */
// Blend stage: weights each texel read and accumulates the three channels.
// Depends on tbs_pkg.
module tbs_blend
    import tbs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  rd_tag_t         tag,
    input  logic [RgbW-1:0] texel,
    output logic            result_valid,
    output logic [OutW-1:0] red_out,
    output logic [OutW-1:0] green_out,
    output logic [OutW-1:0] blue_out
);

    logic [AccW-1:0] acc_reg [3];
    logic [AccW-1:0] acc_next [3];
    logic            valid_reg;
    logic [OutW-1:0] out_reg [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = (tag.first ? '0 : acc_reg[c])
                        + AccW'(texel[c*ChanW +: ChanW]) * AccW'(tag.weight);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tag.valid && tag.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag.valid)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= acc_next[c];
                if (tag.last)
                begin
                    out_reg[c] <= acc_next[c][OutShift +: OutW];
                end
            end
        end
    end

    assign result_valid = valid_reg;
    assign red_out      = out_reg[0];
    assign green_out    = out_reg[1];
    assign blue_out     = out_reg[2];

endmodule

/* sv/wrapped_bilinear_texture_sampler.sv */
// Wrapped bilinear texture sampler, top level; depends on tbs_pkg and the tbs_* modules.
// An item passes the item registers, the texel RAM read with its tag register and the
// blend output registers to its result strobe. The single RAM port takes one access for
// a write or point sample, four for a bilinear one; busy is high until its last read.
// Reset clears control state and loads the registers (256, 256, bilinear); texel RAM is
// undefined until written. Results are strobed for one cycle and cannot be stalled.
module wrapped_bilinear_texture_sampler
    import tbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     command,
    input  logic [15:0]              texel_index,
    input  logic [RgbW-1:0]          texel_rgb,
    input  logic signed [CoordW-1:0] u_coord,
    input  logic signed [CoordW-1:0] v_coord,
    input  logic                     cfg_we,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [SizeW-1:0]         cfg_data,
    output logic                     result_valid,
    output logic [OutW-1:0]          red_out,
    output logic [OutW-1:0]          green_out,
    output logic [OutW-1:0]          blue_out
);

    logic [SizeW-1:0] width_reg, height_reg, width_eff, height_eff;
    logic             mode_reg;
    logic             ram_we;
    logic [AddrW-1:0] ram_addr;
    logic [RgbW-1:0]  ram_wdata, ram_rdata;
    rd_tag_t          tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SizeW'(256);
            height_reg <= SizeW'(256);
            mode_reg   <= MODE_BILINEAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:   width_reg  <= cfg_data;
                REG_TEX_HEIGHT:  height_reg <= cfg_data;
                REG_FILTER_MODE: mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A size of zero behaves as one.
    assign width_eff  = (width_reg == '0)  ? SizeW'(1) : width_reg;
    assign height_eff = (height_reg == '0) ? SizeW'(1) : height_reg;

    tbs_issue u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .texel_index(texel_index),
        .texel_rgb  (texel_rgb),
        .u_coord    (u_coord),
        .v_coord    (v_coord),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .mode       (mode_reg),
        .busy       (busy),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .tag_reg    (tag)
    );

    tbs_ram #(
        .WIDTH(RgbW),
        .DEPTH(TexelCount)
    ) u_texel_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    tbs_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (tag),
        .texel       (ram_rdata),
        .result_valid(result_valid),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out)
    );

endmodule

/* tb/sv/wrapped_bilinear_texture_sampler_test.sv */
// Testbench for wrapped_bilinear_texture_sampler: directed table, then random items,
// every sample checked against its table value or an in-bench texel sampler predictor.
// Depends on tbs_pkg and the RTL of the sampler.
`timescale 1ns / 100ps

module wrapped_bilinear_texture_sampler_test;
    import tbs_pkg::*;

    typedef struct {
        bit                        is_cfg;
        logic [CfgIdxW-1:0]        reg_sel;
        logic [SizeW-1:0]          reg_val;
        logic                      cmd;
        logic [15:0]               index;
        logic [RgbW-1:0]           rgb;
        logic signed [CoordW-1:0]  u;
        logic signed [CoordW-1:0]  v;
        bit                        typed;
        logic [3*OutW-1:0]         want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic command = CMD_WRITE;
    logic [15:0] texel_index = '0;
    logic [RgbW-1:0] texel_rgb = '0;
    logic signed [CoordW-1:0] u_coord = '0;
    logic signed [CoordW-1:0] v_coord = '0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = REG_TEX_WIDTH;
    logic [SizeW-1:0] cfg_data = '0;
    logic result_valid;
    logic [OutW-1:0] red_out, green_out, blue_out;

    logic [RgbW-1:0] texel_mirror [0:TexelCount-1];
    bit written [0:TexelCount-1];
    int unsigned width_reg = 256;
    int unsigned height_reg = 256;
    logic mode_reg = MODE_BILINEAR;
    logic [3*OutW-1:0] pending_colors [$];
    stim_row_t table_rows [$];
    int errors = 0;
    int quiet_cycles = 0;
    bit allow_idle = 1'b1;

    wrapped_bilinear_texture_sampler dut (.*);

    always #4 clk = ~clk;

    task automatic report(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Floor of coord*size/65536, wrapped into [0,size), plus the 8-bit fraction.
    function automatic void locate(input longint coord, input longint size,
                                   output longint idx, output longint frac);
        longint prod, q, r;
        prod = coord * size;
        q = prod >>> 16;
        frac = (prod - q * 65536) >>> (16 - FracBits);
        r = q % size;
        if (r < 0)
            r += size;
        idx = r;
    endfunction

    function automatic logic [RgbW-1:0] texel_at(input longint row, input longint col,
                                                 input longint w);
        return texel_mirror[(row * w + col) % TexelCount];
    endfunction

    function automatic logic [3*OutW-1:0] sample_color(input logic signed [CoordW-1:0] u,
                                                       input logic signed [CoordW-1:0] v);
        longint w, h, x, y, fx, fy, x1, y1, acc, one;
        longint wt [4];
        logic [RgbW-1:0] c [4];
        logic [3*OutW-1:0] res;
        one = 1 << FracBits;
        w = (width_reg == 0) ? 1 : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        locate(longint'(u), w, x, fx);
        locate(longint'(v), h, y, fy);
        if (mode_reg == MODE_POINT) begin
            c[0] = texel_at(y, x, w);
            for (int ch = 0; ch < 3; ch++)
                res[ch*OutW +: OutW] = {c[0][ch*8 +: 8], 8'h00};
            return res;
        end
        x1 = (x + 1 >= w) ? 0 : x + 1;
        y1 = (y + 1 >= h) ? 0 : y + 1;
        c[0] = texel_at(y, x, w);
        c[1] = texel_at(y, x1, w);
        c[2] = texel_at(y1, x1, w);
        c[3] = texel_at(y1, x, w);
        wt[0] = (one - fx) * (one - fy);
        wt[1] = fx * (one - fy);
        wt[2] = fx * fy;
        wt[3] = (one - fx) * fy;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += longint'(c[k][ch*8 +: 8]) * wt[k];
            res[ch*OutW +: OutW] = OutW'(acc >> OutShift);
        end
        return res;
    endfunction

    task automatic idle_gap();
        if (allow_idle && $urandom_range(3) == 0)
            repeat ($urandom_range(14, 1)) @(negedge clk);
    endtask

    // Drives one item from the falling edge and holds it until a rising edge takes it.
    task automatic send_item(input logic cmd, input logic [15:0] index,
                             input logic [RgbW-1:0] rgb, input logic signed [CoordW-1:0] u,
                             input logic signed [CoordW-1:0] v, input bit typed,
                             input logic [3*OutW-1:0] want);
        start = 1'b1;
        command = cmd;
        texel_index = index;
        texel_rgb = rgb;
        u_coord = u;
        v_coord = v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd == CMD_WRITE) begin
            texel_mirror[index] = rgb;
            written[index] = 1'b1;
        end
        else
            pending_colors.push_back(typed ? want : sample_color(u, v));
        @(negedge clk);
        start = 1'b0;
    endtask

    // Writes every texel that a sample at u, v would read and that holds nothing yet.
    task automatic cover_reads(input logic signed [CoordW-1:0] u,
                               input logic signed [CoordW-1:0] v, inout int sent);
        longint w, h, x, y, fx, fy, x1, y1;
        longint addr [4];
        w = (width_reg == 0) ? 1 : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        locate(longint'(u), w, x, fx);
        locate(longint'(v), h, y, fy);
        x1 = (x + 1 >= w) ? 0 : x + 1;
        y1 = (y + 1 >= h) ? 0 : y + 1;
        if (mode_reg == MODE_POINT) begin
            x1 = x;
            y1 = y;
        end
        addr[0] = (y * w + x) % TexelCount;
        addr[1] = (y * w + x1) % TexelCount;
        addr[2] = (y1 * w + x1) % TexelCount;
        addr[3] = (y1 * w + x) % TexelCount;
        for (int k = 0; k < 4; k++) begin
            if (!written[addr[k]]) begin
                send_item(CMD_WRITE, 16'(addr[k]), RgbW'($urandom), '0, '0, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic drain();
        while (pending_colors.size() != 0)
            @(negedge clk);
        // A write may still be in the pipe after the last result.
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] sel, input logic [SizeW-1:0] val);
        drain();
        cfg_we = 1'b1;
        cfg_index = sel;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (sel == REG_TEX_WIDTH)
            width_reg = val;
        else if (sel == REG_TEX_HEIGHT)
            height_reg = val;
        else
            mode_reg = val[0];
    endtask

    function automatic void add_cfg(input logic [CfgIdxW-1:0] sel, input int val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.reg_val = SizeW'(val);
        table_rows.push_back(r);
    endfunction

    function automatic void add_item(input logic cmd, input int index, input int rgb,
                                     input int u, input int v, input bit typed,
                                     input logic [3*OutW-1:0] want);
        stim_row_t r;
        r = '{default: '0};
        r.cmd = cmd;
        r.index = 16'(index);
        r.rgb = RgbW'(rgb);
        r.u = CoordW'(u);
        r.v = CoordW'(v);
        r.typed = typed;
        r.want = want;
        table_rows.push_back(r);
    endfunction

    function automatic logic signed [CoordW-1:0] random_coord();
        case ($urandom_range(3))
            0: return CoordW'($urandom_range(8388607));
            1: return -$signed({1'b0, 23'($urandom_range(8388607))});
            default: return CoordW'($signed(CoordW'($urandom_range(262143))) - 131072);
        endcase
    endfunction

    always @(posedge clk) begin
        if (rst_n && result_valid) begin
            if (pending_colors.size() == 0)
                report($sformatf("unexpected result %h %h %h", red_out, green_out,
                                 blue_out));
            else begin
                logic [3*OutW-1:0] want;
                want = pending_colors.pop_front();
                if (red_out !== want[0 +: OutW])
                    report($sformatf("red %h, expected %h", red_out, want[0 +: OutW]));
                if (green_out !== want[OutW +: OutW])
                    report($sformatf("green %h, expected %h", green_out,
                                     want[OutW +: OutW]));
                if (blue_out !== want[2*OutW +: OutW])
                    report($sformatf("blue %h, expected %h", blue_out,
                                     want[2*OutW +: OutW]));
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("wrapped_bilinear_texture_sampler_test: errors");
            $finish;
        end
    end

    initial begin
        int settings [8][3];
        int sent;
        int dummy;
        bit pressed;
        logic signed [CoordW-1:0] u, v;
        settings = '{'{256, 256, 1}, '{1, 1, 0}, '{0, 0, 1}, '{511, 3, 1},
                     '{5, 7, 0}, '{13, 200, 1}, '{256, 1, 0}, '{2, 300, 1}};
        dummy = 0;
        pressed = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_item(CMD_WRITE, 0, 24'h123456, 0, 0, 1'b0, '0);
        add_item(CMD_SAMPLE, 0, 0, 0, 0, 1'b1, {16'h1200, 16'h3400, 16'h5600});
        add_item(CMD_WRITE, 1, 24'hFFFFFF, 0, 0, 1'b0, '0);
        add_item(CMD_WRITE, 256, 24'hFFFFFF, 0, 0, 1'b0, '0);
        add_item(CMD_WRITE, 257, 24'hFFFFFF, 0, 0, 1'b0, '0);
        add_item(CMD_WRITE, 0, 24'hFFFFFF, 0, 0, 1'b0, '0);
        add_item(CMD_SAMPLE, 0, 0, 128, 128, 1'b1, {3{16'hFF00}});
        add_item(CMD_SAMPLE, 0, 0, -1, -1, 1'b0, '0);
        add_item(CMD_SAMPLE, 0, 0, 8388607, -8388608, 1'b0, '0);
        add_item(CMD_SAMPLE, 0, 0, -8388608, 8388607, 1'b0, '0);
        add_item(CMD_SAMPLE, 0, 0, 65536, -65536, 1'b0, '0);
        add_cfg(REG_FILTER_MODE, MODE_POINT);
        add_item(CMD_WRITE, 65535, 24'h000000, 0, 0, 1'b0, '0);
        add_item(CMD_SAMPLE, 0, 0, -1, -1, 1'b1, '0);
        add_item(CMD_SAMPLE, 0, 0, 32768, -32769, 1'b0, '0);
        add_cfg(REG_TEX_WIDTH, 0);
        add_cfg(REG_TEX_HEIGHT, 0);
        add_item(CMD_SAMPLE, 0, 0, -8388608, 8388607, 1'b1, {3{16'hFF00}});
        add_cfg(REG_TEX_WIDTH, 511);
        add_cfg(REG_TEX_HEIGHT, 511);
        add_item(CMD_SAMPLE, 0, 0, 8388607, 8388607, 1'b0, '0);
        add_cfg(REG_FILTER_MODE, MODE_BILINEAR);
        add_item(CMD_SAMPLE, 0, 0, -1, 8388607, 1'b0, '0);
        // A sample only ever reads texels that were written before it.
        foreach (table_rows[i]) begin
            if (table_rows[i].is_cfg)
                write_reg(table_rows[i].reg_sel, table_rows[i].reg_val);
            else begin
                if (table_rows[i].cmd == CMD_SAMPLE)
                    cover_reads(table_rows[i].u, table_rows[i].v, dummy);
                send_item(table_rows[i].cmd, table_rows[i].index, table_rows[i].rgb,
                          table_rows[i].u, table_rows[i].v, table_rows[i].typed,
                          table_rows[i].want);
            end
        end

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_TEX_WIDTH, SizeW'(settings[p][0]));
            write_reg(REG_TEX_HEIGHT, SizeW'(settings[p][1]));
            write_reg(REG_FILTER_MODE, SizeW'(settings[p][2]));
            allow_idle = (p < 7);
            sent = 0;
            while (sent < 150) begin
                idle_gap();
                if (p == 3 && !pressed && sent >= 75) begin
                    drain();
                    pressed = 1'b1;
                end
                u = random_coord();
                v = random_coord();
                if ($urandom_range(9) < 3)
                    send_item(CMD_WRITE, 16'($urandom), RgbW'($urandom), u, v, 1'b0, '0);
                else begin
                    cover_reads(u, v, sent);
                    send_item(CMD_SAMPLE, 16'($urandom), RgbW'($urandom), u, v, 1'b0, '0);
                end
                sent++;
            end
        end

        while (pending_colors.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("wrapped_bilinear_texture_sampler_test: clean");
        else
            $display("wrapped_bilinear_texture_sampler_test: errors");
        $finish;
    end

endmodule

/* sim.f */
sv/tbs_pkg.sv
sv/tbs_ram.sv
sv/tbs_issue.sv
sv/tbs_blend.sv
sv/wrapped_bilinear_texture_sampler.sv
tb/sv/wrapped_bilinear_texture_sampler_test.sv
